@@ rtl/core/ftach_pkg.sv @@
// shared types, register codes and constants for the fan tach rpm meter
package ftach_pkg;

  localparam int PULSE_COUNT_WIDTH = 16;

  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 24;

  localparam int DEBOUNCE_W  = 16;
  localparam int WINDOW_W    = 24;
  localparam int RPP_W       = 8;
  localparam int SINCE_W     = 17;
  localparam int RPM_W       = 24;
  localparam int PULSE_OUT_W = 16;

  // widest pulses * rpm_per_pulse product over the parameter range
  localparam int PROD_EXT_W  = 40;
  // widest pulse tally over the parameter range
  localparam int PULSE_EXT_W = 32;

  localparam int QUEUE_DEPTH = 4;

  // (2*old + 3*raw) fits in 27 bits; divided by 5 through a reciprocal
  localparam int SUM_W         = 27;
  localparam int DIV5_RECIP_W  = 28;
  localparam logic [DIV5_RECIP_W-1:0] DIV5_RECIP = 28'd214748365;
  localparam int DIV5_SHIFT    = 30;
  localparam int DIV_PROD_W    = SUM_W + DIV5_RECIP_W;

  localparam logic [DEBOUNCE_W-1:0] DEBOUNCE_RESET = 16'd800;
  localparam logic [WINDOW_W-1:0]   WINDOW_RESET   = 24'd1000000;
  localparam logic [RPP_W-1:0]      RPP_RESET      = 8'd30;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_DEBOUNCE = 2'd0,
    CFG_WINDOW   = 2'd1,
    CFG_RPP      = 2'd2
  } cfg_idx_t;

  typedef struct packed {
    logic [DEBOUNCE_W-1:0] debounce_ticks;
    logic [WINDOW_W-1:0]   window_ticks;
    logic [RPP_W-1:0]      rpm_per_pulse;
  } cfg_t;

endpackage

@@ rtl/core/ftach_cfg.sv @@
// configuration register file for the fan tach rpm meter
module ftach_cfg (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [ftach_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [ftach_pkg::CFG_DATA_W-1:0]   cfg_data,
  output ftach_pkg::cfg_t                    cfg
);

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.debounce_ticks <= ftach_pkg::DEBOUNCE_RESET;
      cfg.window_ticks   <= ftach_pkg::WINDOW_RESET;
      cfg.rpm_per_pulse  <= ftach_pkg::RPP_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (ftach_pkg::cfg_idx_t'(cfg_index))
        ftach_pkg::CFG_DEBOUNCE: begin
          cfg.debounce_ticks <= cfg_data[ftach_pkg::DEBOUNCE_W-1:0];
        end
        ftach_pkg::CFG_WINDOW: begin
          cfg.window_ticks <= cfg_data[ftach_pkg::WINDOW_W-1:0];
        end
        ftach_pkg::CFG_RPP: begin
          cfg.rpm_per_pulse <= cfg_data[ftach_pkg::RPP_W-1:0];
        end
        default: begin
          // unknown index, ignored
        end
      endcase
    end
  end

endmodule

@@ rtl/core/ftach_front.sv @@
// front end: debounce of tach edges, pulse tally and window timing
module ftach_front #(
  parameter int PCW = ftach_pkg::PULSE_COUNT_WIDTH
) (
  input  logic                 clk,
  input  logic                 rst,
  input  ftach_pkg::cfg_t      cfg,
  input  logic                 tick_valid,
  output logic                 tick_stall,
  input  logic                 tach_edge,
  input  logic                 q_full,
  output logic                 q_push,
  output logic [PCW-1:0]       q_data
);

  logic [ftach_pkg::SINCE_W-1:0]  since_last_edge;
  logic [PCW-1:0]                 pulse_tally;
  logic [ftach_pkg::WINDOW_W-1:0] window_elapsed;

  logic [ftach_pkg::SINCE_W-1:0]  since_inc;
  logic [PCW-1:0]                 tally_upd;
  logic [ftach_pkg::WINDOW_W-1:0] win_inc;
  logic                           edge_ok;
  logic                           close;
  logic                           accept;

  assign tick_stall = q_full;
  assign accept     = tick_valid && !tick_stall;

  always_comb begin
    since_inc = (since_last_edge == '1) ? since_last_edge
                                        : since_last_edge + 1'b1;
    edge_ok   = tach_edge &&
                (since_inc > ftach_pkg::SINCE_W'(cfg.debounce_ticks));
    tally_upd = pulse_tally;
    if (edge_ok && (pulse_tally != '1)) begin
      tally_upd = pulse_tally + 1'b1;
    end
    win_inc = window_elapsed + 1'b1;
    // a zero window length closes on every tick
    close   = (win_inc >= cfg.window_ticks);
  end

  assign q_push = accept && close;
  assign q_data = tally_upd;

  always_ff @(posedge clk) begin
    if (rst) begin
      since_last_edge <= '0;
      pulse_tally     <= '0;
      window_elapsed  <= '0;
    end else if (accept) begin
      since_last_edge <= edge_ok ? '0 : since_inc;
      if (close) begin
        pulse_tally    <= '0;
        window_elapsed <= '0;
      end else begin
        pulse_tally    <= tally_upd;
        window_elapsed <= win_inc;
      end
    end
  end

endmodule

@@ rtl/core/ftach_queue.sv @@
// short queue of closed-window pulse counts between front and back
module ftach_queue #(
  parameter int W     = ftach_pkg::PULSE_COUNT_WIDTH,
  parameter int DEPTH = ftach_pkg::QUEUE_DEPTH
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  logic [W-1:0] push_data,
  input  logic         pop,
  output logic [W-1:0] pop_data,
  output logic         full,
  output logic         empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [W-1:0]     entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  logic do_push;
  logic do_pop;

  assign full     = (count == CNT_W'(DEPTH));
  assign empty    = (count == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_data;
    end
  end

endmodule

@@ rtl/core/ftach_back.sv @@
// back end: raw rpm multiply, then 40/60 smoothing and output register
module ftach_back #(
  parameter int PCW = ftach_pkg::PULSE_COUNT_WIDTH
) (
  input  logic                                clk,
  input  logic                                rst,
  input  ftach_pkg::cfg_t                     cfg,
  input  logic                                q_empty,
  input  logic [PCW-1:0]                      q_data,
  output logic                                q_pop,
  output logic                                rpm_valid,
  input  logic                                rpm_stall,
  output logic [ftach_pkg::RPM_W-1:0]         smoothed_rpm,
  output logic [ftach_pkg::RPM_W-1:0]         raw_rpm,
  output logic [ftach_pkg::PULSE_OUT_W-1:0]   pulses_in_window
);

  localparam int PROD_W = PCW + ftach_pkg::RPP_W;

  logic                                s1_valid;
  logic [ftach_pkg::RPM_W-1:0]         s1_raw;
  logic [ftach_pkg::PULSE_OUT_W-1:0]   s1_pulses;
  logic [ftach_pkg::RPM_W-1:0]         rpm_smoothed;

  logic adv1;
  logic adv2;

  logic [PROD_W-1:0]                   prod;
  logic [ftach_pkg::PROD_EXT_W-1:0]    prod_ext;
  logic [ftach_pkg::PULSE_EXT_W-1:0]   pulses_ext;
  logic [ftach_pkg::RPM_W-1:0]         raw_c;
  logic [ftach_pkg::PULSE_OUT_W-1:0]   pulses_c;

  logic [ftach_pkg::SUM_W-1:0]         blend_sum;
  logic [ftach_pkg::DIV_PROD_W-1:0]    div_prod;
  logic [ftach_pkg::RPM_W-1:0]         blend;
  logic [ftach_pkg::RPM_W-1:0]         smooth_c;

  assign adv2  = !rpm_valid || !rpm_stall;
  assign adv1  = !s1_valid || adv2;
  assign q_pop = !q_empty && adv1;

  // stage 1: pulses times rpm per pulse, saturated
  always_comb begin
    prod       = PROD_W'(q_data) * PROD_W'(cfg.rpm_per_pulse);
    prod_ext   = ftach_pkg::PROD_EXT_W'(prod);
    raw_c      = (|prod_ext[ftach_pkg::PROD_EXT_W-1:ftach_pkg::RPM_W]) ? '1
                 : prod_ext[ftach_pkg::RPM_W-1:0];
    pulses_ext = ftach_pkg::PULSE_EXT_W'(q_data);
    pulses_c   = (|pulses_ext[ftach_pkg::PULSE_EXT_W-1:ftach_pkg::PULSE_OUT_W]) ? '1
                 : pulses_ext[ftach_pkg::PULSE_OUT_W-1:0];
  end

  // stage 2: (4*old + 6*raw)/10 == (2*old + 3*raw)/5, via reciprocal of 5
  always_comb begin
    blend_sum = (ftach_pkg::SUM_W'(rpm_smoothed) << 1)
              + ftach_pkg::SUM_W'(s1_raw)
              + (ftach_pkg::SUM_W'(s1_raw) << 1);
    div_prod  = ftach_pkg::DIV_PROD_W'(blend_sum)
              * ftach_pkg::DIV_PROD_W'(ftach_pkg::DIV5_RECIP);
    blend     = div_prod[ftach_pkg::DIV5_SHIFT +: ftach_pkg::RPM_W];
    smooth_c  = (rpm_smoothed == '0) ? s1_raw : blend;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid     <= 1'b0;
      rpm_valid    <= 1'b0;
      rpm_smoothed <= '0;
    end else begin
      if (adv1) begin
        s1_valid <= q_pop;
      end
      if (adv2) begin
        rpm_valid <= s1_valid;
        if (s1_valid) begin
          rpm_smoothed <= smooth_c;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      s1_raw    <= raw_c;
      s1_pulses <= pulses_c;
    end
    if (adv2 && s1_valid) begin
      smoothed_rpm     <= smooth_c;
      raw_rpm          <= s1_raw;
      pulses_in_window <= s1_pulses;
    end
  end

endmodule

@@ rtl/core/fan_tach_rpm_meter.sv @@
// fan tach rpm meter top level: config, front end, queue, back end
// one tick word is taken every cycle while the four-entry window queue has room
// a closing tick's rpm word passes the window queue, the multiply stage and the output register; a stall holds it
// the back end retires one window word per cycle while rpm_stall is low: multiply stage, then smoothing
// stage whose divide by ten is a reciprocal multiply on the smoothed feedback
// synchronous reset clears counters, smoothed rpm and queue, and loads register defaults
module fan_tach_rpm_meter #(
  parameter int PULSE_COUNT_WIDTH = ftach_pkg::PULSE_COUNT_WIDTH
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                tick_valid,
  output logic                                tick_stall,
  input  logic                                tach_edge,
  output logic                                rpm_valid,
  input  logic                                rpm_stall,
  output logic [ftach_pkg::RPM_W-1:0]         smoothed_rpm,
  output logic [ftach_pkg::RPM_W-1:0]         raw_rpm,
  output logic [ftach_pkg::PULSE_OUT_W-1:0]   pulses_in_window,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [ftach_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [ftach_pkg::CFG_DATA_W-1:0]    cfg_data
);

  ftach_pkg::cfg_t              cfg;
  logic                         q_push;
  logic                         q_pop;
  logic                         q_full;
  logic                         q_empty;
  logic [PULSE_COUNT_WIDTH-1:0] q_wr_data;
  logic [PULSE_COUNT_WIDTH-1:0] q_rd_data;

  ftach_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  ftach_front #(
    .PCW (PULSE_COUNT_WIDTH)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .tick_valid (tick_valid),
    .tick_stall (tick_stall),
    .tach_edge  (tach_edge),
    .q_full     (q_full),
    .q_push     (q_push),
    .q_data     (q_wr_data)
  );

  ftach_queue #(
    .W     (PULSE_COUNT_WIDTH),
    .DEPTH (ftach_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_wr_data),
    .pop       (q_pop),
    .pop_data  (q_rd_data),
    .full      (q_full),
    .empty     (q_empty)
  );

  ftach_back #(
    .PCW (PULSE_COUNT_WIDTH)
  ) u_back (
    .clk              (clk),
    .rst              (rst),
    .cfg              (cfg),
    .q_empty          (q_empty),
    .q_data           (q_rd_data),
    .q_pop            (q_pop),
    .rpm_valid        (rpm_valid),
    .rpm_stall        (rpm_stall),
    .smoothed_rpm     (smoothed_rpm),
    .raw_rpm          (raw_rpm),
    .pulses_in_window (pulses_in_window)
  );

  // a closed window never meets a full queue
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    q_push |-> !q_full)
    else $error("window word pushed into full queue");

  // no pulses means no raw rpm
  a_zero_raw: assert property (@(posedge clk) disable iff (rst)
    (rpm_valid && (pulses_in_window == '0)) |-> (raw_rpm == '0))
    else $error("raw rpm nonzero with zero pulses");

  // nothing pops from an empty queue
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    q_empty |-> !q_pop)
    else $error("pop from empty queue");

  // reset leaves no result pending
  a_reset_clear: assert property (@(posedge clk)
    rst |=> !rpm_valid)
    else $error("result valid right after reset");

endmodule

@@ verif/tb.sv @@
// testbench for the fan tach rpm meter: tick stream, register writes, rpm word checks
`timescale 1ns / 1ps

module tb;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int SETTLE_CYCLES  = 8;
  localparam logic [ftach_pkg::CFG_INDEX_W-1:0] CFG_UNUSED = 2'd3;
  localparam logic [ftach_pkg::SINCE_W-1:0] SINCE_MAX = '1;

  typedef struct packed {
    logic [ftach_pkg::RPM_W-1:0]       smoothed;
    logic [ftach_pkg::RPM_W-1:0]       raw;
    logic [ftach_pkg::PULSE_OUT_W-1:0] pulses;
  } rpm_word_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic tick_valid = 1'b0;
  logic tick_stall;
  logic tach_edge = 1'b0;
  logic rpm_valid;
  logic rpm_stall = 1'b0;
  logic [ftach_pkg::RPM_W-1:0] smoothed_rpm;
  logic [ftach_pkg::RPM_W-1:0] raw_rpm;
  logic [ftach_pkg::PULSE_OUT_W-1:0] pulses_in_window;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [ftach_pkg::CFG_INDEX_W-1:0] cfg_index = ftach_pkg::CFG_DEBOUNCE;
  logic [ftach_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  fan_tach_rpm_meter dut (
    .clk              (clk),
    .rst              (rst),
    .tick_valid       (tick_valid),
    .tick_stall       (tick_stall),
    .tach_edge        (tach_edge),
    .rpm_valid        (rpm_valid),
    .rpm_stall        (rpm_stall),
    .smoothed_rpm     (smoothed_rpm),
    .raw_rpm          (raw_rpm),
    .pulses_in_window (pulses_in_window),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  // meter mirror: registers and counters
  logic [ftach_pkg::DEBOUNCE_W-1:0]        deb_ticks;
  logic [ftach_pkg::WINDOW_W-1:0]          win_ticks;
  logic [ftach_pkg::RPP_W-1:0]             rpp;
  logic [ftach_pkg::SINCE_W-1:0]           since_cnt;
  logic [ftach_pkg::PULSE_COUNT_WIDTH-1:0] tally;
  logic [ftach_pkg::WINDOW_W-1:0]          win_cnt;
  logic [ftach_pkg::RPM_W-1:0]             smooth_q;

  rpm_word_t rpm_expected[$];
  int mismatches = 0;
  int quiet_cycles = 0;
  int idle_pct = 0;
  int stall_pct = 0;

  task automatic report_mismatch(input string msg);
    $display("tb: mismatch: %s", msg);
    mismatches++;
  endtask

  task automatic meter_reset();
    deb_ticks = ftach_pkg::DEBOUNCE_RESET;
    win_ticks = ftach_pkg::WINDOW_RESET;
    rpp = ftach_pkg::RPP_RESET;
    since_cnt = '0;
    tally = '0;
    win_cnt = '0;
    smooth_q = '0;
    rpm_expected.delete();
  endtask

  task automatic meter_write_reg(input logic [ftach_pkg::CFG_INDEX_W-1:0] idx,
                                 input logic [ftach_pkg::CFG_DATA_W-1:0] data);
    case (idx)
      ftach_pkg::CFG_DEBOUNCE: deb_ticks = data[ftach_pkg::DEBOUNCE_W-1:0];
      ftach_pkg::CFG_WINDOW: win_ticks = data[ftach_pkg::WINDOW_W-1:0];
      ftach_pkg::CFG_RPP: rpp = data[ftach_pkg::RPP_W-1:0];
      default: ;
    endcase
  endtask

  task automatic meter_tick(input logic edge_bit);
    logic [ftach_pkg::SINCE_W:0] elapsed;
    logic [63:0] prod;
    logic [63:0] blend;
    rpm_word_t w;
    elapsed = {1'b0, since_cnt} + 1'b1;
    if (elapsed > SINCE_MAX) elapsed = SINCE_MAX;
    if (edge_bit && elapsed > deb_ticks) begin
      if (tally != '1) tally = tally + 1'b1;
      since_cnt = '0;
    end else begin
      since_cnt = elapsed[ftach_pkg::SINCE_W-1:0];
    end
    win_cnt = win_cnt + 1'b1;
    // window length zero behaves like one
    if (win_cnt >= win_ticks) begin
      prod = 64'(tally) * 64'(rpp);
      if (prod > 64'hFF_FFFF) prod = 64'hFF_FFFF;
      if (smooth_q == '0) blend = prod;
      else blend = (64'd4 * 64'(smooth_q) + 64'd6 * prod) / 64'd10;
      smooth_q = blend[ftach_pkg::RPM_W-1:0];
      w.smoothed = smooth_q;
      w.raw = prod[ftach_pkg::RPM_W-1:0];
      w.pulses = (64'(tally) > 64'hFFFF) ? '1 : ftach_pkg::PULSE_OUT_W'(tally);
      rpm_expected.push_back(w);
      tally = '0;
      win_cnt = '0;
    end
  endtask

  task automatic check_word();
    rpm_word_t want;
    if (rpm_expected.size() == 0) begin
      report_mismatch($sformatf("unexpected word smoothed %0d raw %0d pulses %0d",
                                smoothed_rpm, raw_rpm, pulses_in_window));
    end else begin
      want = rpm_expected.pop_front();
      if (smoothed_rpm !== want.smoothed)
        report_mismatch($sformatf("smoothed_rpm got %0d want %0d",
                                  smoothed_rpm, want.smoothed));
      if (raw_rpm !== want.raw)
        report_mismatch($sformatf("raw_rpm got %0d want %0d", raw_rpm, want.raw));
      if (pulses_in_window !== want.pulses)
        report_mismatch($sformatf("pulses_in_window got %0d want %0d",
                                  pulses_in_window, want.pulses));
    end
  endtask

  // values read here are the ones present at the edge
  always @(posedge clk) begin
    if (rst) begin
      meter_reset();
      quiet_cycles = 0;
    end else begin
      if (cfg_valid && cfg_ready) meter_write_reg(cfg_index, cfg_data);
      if (tick_valid && !tick_stall) meter_tick(tach_edge);
      if (rpm_valid && !rpm_stall) check_word();
      if ((cfg_valid && cfg_ready) || (tick_valid && !tick_stall) ||
          (rpm_valid && !rpm_stall)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
          $display("tb: failure");
          $finish;
        end
      end
    end
  end

  always @(posedge clk) begin
    rpm_stall <= ($urandom_range(0, 99) < stall_pct);
  end

  task automatic send_tick(input logic edge_bit);
    while ($urandom_range(0, 99) < idle_pct) begin
      tick_valid <= 1'b0;
      @(posedge clk);
    end
    tick_valid <= 1'b1;
    tach_edge <= edge_bit;
    do @(posedge clk); while (tick_stall);
  endtask

  task automatic write_reg(input logic [ftach_pkg::CFG_INDEX_W-1:0] idx,
                           input logic [ftach_pkg::CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // upper data bits beyond each register width are junk and must be dropped
  task automatic set_config(input logic [ftach_pkg::DEBOUNCE_W-1:0] deb,
                            input logic [ftach_pkg::WINDOW_W-1:0] win,
                            input logic [ftach_pkg::RPP_W-1:0] per_pulse);
    write_reg(ftach_pkg::CFG_DEBOUNCE, {8'($urandom), deb});
    write_reg(ftach_pkg::CFG_WINDOW, win);
    write_reg(ftach_pkg::CFG_RPP, {16'($urandom), per_pulse});
  endtask

  task automatic hold_until_empty();
    tick_valid <= 1'b0;
    do @(negedge clk); while (rpm_expected.size() != 0);
    @(posedge clk);
  endtask

  task automatic drain_results();
    hold_until_empty();
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_idling(input int send_idle, input int recv_stall);
    idle_pct = send_idle;
    stall_pct = recv_stall;
  endtask

  // default registers: edges right after reset fall inside the debounce time
  task automatic test_reset_defaults();
    set_idling(0, 0);
    repeat (4) send_tick(1'b1);
    drain_results();
  endtask

  task automatic test_debounce_window();
    set_config(16'd2, 24'd6, 8'd255);
    repeat (8) send_tick(1'b1);
    send_tick(1'b0);
    send_tick(1'b1);
    send_tick(1'b0);
    send_tick(1'b1);
    drain_results();
  endtask

  task automatic test_zero_window_and_rpm();
    set_config(16'd0, 24'd0, 8'd0);
    send_tick(1'b1);
    send_tick(1'b0);
    drain_results();
    write_reg(ftach_pkg::CFG_RPP, 24'd1);
    write_reg(CFG_UNUSED, 24'hFF_FFFF);
    send_tick(1'b1);
    send_tick(1'b1);
    send_tick(1'b0);
    drain_results();
  endtask

  // a shorter window than the running count closes on the next tick
  task automatic test_window_retarget();
    set_config(16'd1, 24'hFF_FFFF, 8'd100);
    repeat (5) send_tick(1'b1);
    drain_results();
    write_reg(ftach_pkg::CFG_WINDOW, 24'd1);
    send_tick(1'b1);
    send_tick(1'b0);
    drain_results();
  endtask

  // debounce count runs on across window closes; an edge one tick early is rejected
  task automatic test_long_quiet();
    set_idling(0, 0);
    set_config(16'd100, 24'd64, 8'd7);
    repeat (150) send_tick(1'b0);
    send_tick(1'b1);
    repeat (99) send_tick(1'b0);
    send_tick(1'b1);
    send_tick(1'b1);
    repeat (10) send_tick(1'b0);
    drain_results();
  endtask

  task automatic test_random_traffic();
    int send_idle[4];
    int recv_stall[4];
    logic [ftach_pkg::DEBOUNCE_W-1:0] deb;
    logic [ftach_pkg::WINDOW_W-1:0] win;
    logic [ftach_pkg::RPP_W-1:0] per_pulse;
    int edge_pct;
    send_idle = '{0, 61, 0, 25};
    recv_stall = '{0, 0, 61, 25};
    for (int ph = 0; ph < 4; ph++) begin
      for (int blk = 0; blk < 4; blk++) begin
        set_idling(0, recv_stall[ph]);
        deb = ftach_pkg::DEBOUNCE_W'($urandom_range(0, 12));
        win = ($urandom_range(0, 5) == 0) ? ftach_pkg::WINDOW_W'($urandom_range(0, 2))
                                          : ftach_pkg::WINDOW_W'($urandom_range(3, 40));
        per_pulse = ($urandom_range(0, 7) == 0) ? 8'd255
                                                : ftach_pkg::RPP_W'($urandom_range(0, 255));
        set_config(deb, win, per_pulse);
        edge_pct = $urandom_range(15, 90);
        set_idling(send_idle[ph], recv_stall[ph]);
        for (int n = 0; n < 110; n++) begin
          send_tick($urandom_range(0, 99) < edge_pct);
          if ($urandom_range(0, 199) == 0) hold_until_empty();
        end
        drain_results();
      end
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_defaults();
    test_debounce_window();
    test_zero_window_and_rpm();
    test_window_retarget();
    test_long_quiet();
    test_random_traffic();
    set_idling(0, 0);
    drain_results();
    if (rpm_expected.size() != 0)
      report_mismatch($sformatf("%0d rpm words never arrived", rpm_expected.size()));
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
